/* hw/rtl/cfd_pkg.sv */
// Package: shared constants, types and helpers of the checksummed frame deframer.
`default_nettype none

package cfd_pkg;

    // Number of body bytes in one frame
    localparam int BODY_BYTES = 26;

    // Width of a body position or store address
    localparam int POS_W = (BODY_BYTES > 1) ? $clog2(BODY_BYTES) : 1;

    // Width of the body_index field on the output
    localparam int IDX_W = 5;

    localparam logic [POS_W-1:0] BODY_LAST = POS_W'(BODY_BYTES - 1);

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] TRAILER    = 8'h88;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [2:0] {
        ST_HUNT  = 3'd0,
        ST_HDR2  = 3'd1,
        ST_BODY  = 3'd2,
        ST_CSUM  = 3'd3,
        ST_TRAIL = 3'd4,
        ST_EMIT  = 3'd5
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic sum_first;   // load the sum with the received byte
        logic sum_add;     // add the received byte to the sum
        logic sum_clear;   // clear the sum and the body position
        logic pos_clear;   // clear the body position
        logic store_wr;    // write the byte into the body store, advance position
        logic emit_load;   // read the next body byte into the output stage
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_hdr1;
        logic is_hdr2;
        logic is_trailer;
        logic sum_match;
        logic pos_last;
        logic emit_last;
        logic out_busy;    // output stage holds a beat that is stalled
    } sts_t;

    // Wrap a body position onto the output index field
    function automatic logic [IDX_W-1:0] to_index(input pos_t pos);
        logic [POS_W+IDX_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, pos};
        return wide[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cfd_ctrl.sv */
// Controller: frame parse state machine and output emit sequencing.
`default_nettype none

module cfd_ctrl
    import cfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg == ST_EMIT);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (accept && sts.is_hdr1)
                begin
                    state_next = ST_HDR2;
                end
            end
            ST_HDR2:
            begin
                if (accept)
                begin
                    state_next = sts.is_hdr2 ? ST_BODY : ST_HUNT;
                end
            end
            ST_BODY:
            begin
                if (accept && sts.pos_last)
                begin
                    state_next = ST_CSUM;
                end
            end
            ST_CSUM:
            begin
                if (accept)
                begin
                    state_next = sts.sum_match ? ST_TRAIL : ST_HUNT;
                end
            end
            ST_TRAIL:
            begin
                if (accept)
                begin
                    state_next = sts.is_trailer ? ST_EMIT : ST_HUNT;
                end
            end
            ST_EMIT:
            begin
                if (!sts.out_busy && sts.emit_last)
                begin
                    state_next = ST_HUNT;
                end
            end
            default:
            begin
                // treat an unused code as hunting
                if (accept && sts.is_hdr1)
                begin
                    state_next = ST_HDR2;
                end
                else
                begin
                    state_next = ST_HUNT;
                end
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (accept)
                begin
                    cmd.sum_first = sts.is_hdr1;
                    cmd.sum_clear = !sts.is_hdr1;
                end
            end
            ST_HDR2:
            begin
                if (accept)
                begin
                    cmd.sum_add   = sts.is_hdr2;
                    cmd.pos_clear = sts.is_hdr2;
                    cmd.sum_clear = !sts.is_hdr2;
                end
            end
            ST_BODY:
            begin
                if (accept)
                begin
                    cmd.sum_add  = 1'b1;
                    cmd.store_wr = 1'b1;
                end
            end
            ST_CSUM:
            begin
                if (accept)
                begin
                    cmd.sum_clear = !sts.sum_match;
                end
            end
            ST_TRAIL:
            begin
                if (accept)
                begin
                    cmd.sum_clear = 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_load = !sts.out_busy;
            end
            default:
            begin
                if (accept)
                begin
                    cmd.sum_first = sts.is_hdr1;
                    cmd.sum_clear = !sts.is_hdr1;
                end
            end
        endcase
    end

    // Store writes come only from body parsing
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> (state_reg == ST_BODY && !in_stall))
        else $error("body store written outside body phase");

    // Loading the last body byte ends the emit burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && sts.emit_last) |=> (state_reg == ST_HUNT))
        else $error("emit burst did not end after last body byte");

    // A good trailer starts an emit burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRAIL && accept && sts.is_trailer) |=> in_stall)
        else $error("good trailer did not start emit");

endmodule

`default_nettype wire

/* hw/rtl/cfd_dp.sv */
// Datapath: running checksum, body position, body store and output stage.
`default_nettype none

module cfd_dp
    import cfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        rx_byte,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             body_byte,
    output logic [IDX_W-1:0]       body_index,
    output logic                   frame_last
);

    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    pos_t             pos_reg;
    pos_t             pos_next;
    pos_t             emit_idx_reg;
    pos_t             emit_idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [IDX_W-1:0] index_reg;
    logic             last_reg;

    always_comb
    begin
        sum_next = sum_reg;
        pos_next = pos_reg;
        if (cmd.sum_clear)
        begin
            sum_next = '0;
            pos_next = '0;
        end
        else
        begin
            if (cmd.sum_first)
            begin
                sum_next = rx_byte;
            end
            else if (cmd.sum_add)
            begin
                sum_next = sum_reg + rx_byte;
            end
            if (cmd.pos_clear || (cmd.store_wr && pos_reg == BODY_LAST))
            begin
                pos_next = '0;
            end
            else if (cmd.store_wr)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            emit_idx_next  = (emit_idx_reg == BODY_LAST) ? '0 : emit_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            pos_reg       <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Index and last flag travel with the RAM read data
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            index_reg <= to_index(emit_idx_reg);
            last_reg  <= (emit_idx_reg == BODY_LAST);
        end
    end

    cfd_ram #(
        .WIDTH (8),
        .DEPTH (BODY_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store_wr),
        .wr_addr (pos_reg),
        .wr_data (rx_byte),
        .rd_en   (cmd.emit_load),
        .rd_addr (emit_idx_reg),
        .rd_data (body_byte)
    );

    assign out_valid  = out_valid_reg;
    assign body_index = index_reg;
    assign frame_last = last_reg;

    assign sts.is_hdr1    = (rx_byte == HDR_FIRST);
    assign sts.is_hdr2    = (rx_byte == HDR_SECOND);
    assign sts.is_trailer = (rx_byte == TRAILER);
    assign sts.sum_match  = (rx_byte == sum_reg);
    assign sts.pos_last   = (pos_reg == BODY_LAST);
    assign sts.emit_last  = (emit_idx_reg == BODY_LAST);
    assign sts.out_busy   = out_valid_reg && out_stall;

    // Never overwrite a stalled output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !(out_valid_reg && out_stall))
        else $error("output stage overwritten while stalled");

    // Emit pointer is back at the first body position once the last beat is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && emit_idx_reg == BODY_LAST) |=> (emit_idx_reg == '0))
        else $error("emit pointer did not wrap after last beat");

    // The store is never written during an emit burst
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> (emit_idx_reg == '0 && !cmd.emit_load))
        else $error("body store written while emitting");

endmodule

`default_nettype wire

/* hw/rtl/checksummed_frame_deframer_top.sv */
// Top level: fixed-length frame deframer with additive checksum.
// Input: one byte beat per cycle while parsing; a frame is 55 AA, body, checksum, 88.
// Emit: the emit state, set by a good trailer, registers each body beat for output.
// Throughput: 1 input beat per cycle, except that input stalls for the emit burst
//   of all 26 body beats (one per cycle unless the output stalls) after a good frame.
// Reset: rst_n asynchronous, active low; parser returns to hunting, no output beat held.
`default_nettype none

module checksummed_frame_deframer_top
    import cfd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       rx_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            body_byte,
    output logic [IDX_W-1:0]      body_index,
    output logic                  frame_last
);

    cmd_t cmd;
    sts_t sts;

    // Parse state machine; holds the input side while a body burst drains
    cfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Checksum, body store and the output stage (RAM read register is the
    // body_byte register, so the next frame may parse while a beat waits)
    cfd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .body_byte  (body_byte),
        .body_index (body_index),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire
